// File: rtl/bounded_deque_with_scale_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SCALE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SCALE_MACROS_SVH
`ifndef ASSERT_OFF
`define BDQ_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define BDQ_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`else
`define BDQ_ASSERT(lbl, cond, msg)
`define BDQ_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and codes shared by the deque control and its cell chain.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int WORD_W = 32;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_CLEAR      = 3'd4,
		OP_DUMP       = 3'd5,
		OP_SCALE      = 3'd6
	} op_t;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	// per-cycle action applied to every cell of the chain
	typedef enum logic [2:0] {
		CA_HOLD,
		CA_SHR,    // shift toward back, new word enters at front
		CA_PUSHB,  // first free cell takes the new word
		CA_SHL,    // shift toward front, front word leaves
		CA_CLR,
		CA_ROT     // rotate occupied cells by one, feed lands in last one
	} cell_act_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	typedef struct packed {
		cell_act_t           act;
		logic [WORD_W-1:0]   push_val;
		logic [WORD_W-1:0]   feed;
	} cell_cmd_t;

endpackage

// File: rtl/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One deque slot: a data word and an occupied bit, updated from neighbors.
// ----------------------------------------------------------------------------
module bdq_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bdq_pkg::cell_cmd_t        cmd,
	input  logic [bdq_pkg::WORD_W-1:0] left_data,
	input  logic                      left_occ,
	input  logic [bdq_pkg::WORD_W-1:0] right_data,
	input  logic                      right_occ,
	output logic [bdq_pkg::WORD_W-1:0] data,
	output logic                      occ
);
	import bdq_pkg::*;

	logic [WORD_W-1:0] data_q;
	logic              occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			unique case (cmd.act)
				CA_SHR:   occ_q <= left_occ;
				CA_PUSHB: if (left_occ) occ_q <= 1'b1;
				CA_SHL:   occ_q <= right_occ;
				CA_CLR:   occ_q <= 1'b0;
				default:  occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.act)
			CA_SHR:   data_q <= left_data;
			CA_PUSHB: if (!occ_q && left_occ) data_q <= cmd.push_val;
			CA_SHL:   data_q <= right_data;
			CA_ROT:   if (occ_q) data_q <= right_occ ? right_data : cmd.feed;
			default:  data_q <= data_q;
		endcase
	end

	assign data = data_q;
	assign occ  = occ_q;

endmodule

// File: rtl/bdq_chain.sv
// ----------------------------------------------------------------------------
// bdq_chain
// Row of DEPTH cells; cell 0 holds the front word.
// ----------------------------------------------------------------------------
module bdq_chain #(
	parameter int DEPTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bdq_pkg::cell_cmd_t        cmd,
	output logic [bdq_pkg::WORD_W-1:0] head_data,
	output logic [DEPTH-1:0]          occ_vec
);
	import bdq_pkg::*;

	logic [WORD_W-1:0] cell_data [DEPTH];
	logic [WORD_W-1:0] lft_data  [DEPTH];
	logic [WORD_W-1:0] rgt_data  [DEPTH];
	logic [DEPTH-1:0]  lft_occ;
	logic [DEPTH-1:0]  rgt_occ;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lft_data[i] = cmd.push_val;
			assign lft_occ[i]  = 1'b1;
		end else begin : g_mid_l
			assign lft_data[i] = cell_data[i-1];
			assign lft_occ[i]  = occ_vec[i-1];
		end
		if (i == DEPTH-1) begin : g_last
			assign rgt_data[i] = '0;
			assign rgt_occ[i]  = 1'b0;
		end else begin : g_mid_r
			assign rgt_data[i] = cell_data[i+1];
			assign rgt_occ[i]  = occ_vec[i+1];
		end

		bdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_data  (lft_data[i]),
			.left_occ   (lft_occ[i]),
			.right_data (rgt_data[i]),
			.right_occ  (rgt_occ[i]),
			.data       (cell_data[i]),
			.occ        (occ_vec[i])
		);
	end

	assign head_data = cell_data[0];

endmodule

// File: rtl/bounded_deque_with_scale.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_scale
// Double-ended queue of signed 32-bit words with dump and scale-all.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid / cmd_stall) takes opcode and operand_value.
//   Response channel (rsp_valid / rsp_stall) returns data_value, entry_count,
//   status_code and last_flag; last_flag marks the final word of a command.
//   Push, pop front, clear, the unused code and every full or empty case finish
//   in the accept cycle; their word is registered there and appears in the
//   next cycle. They run back to back at one command a cycle while responses
//   are not stalled.
//   Pop back, dump and scale walk the cell row one step per stored entry, once
//   per cycle unless a stalled response holds the step. Dump and scale rotate
//   the row at each step; pop back rotates until the tail reaches the front and
//   then shifts it out. Dump gives one word per rotation, the first from the
//   first rotation; pop back gives its word with the final shift and scale
//   its word with the last rotation. The command channel stalls while a walk
//   runs or while the response register is full and stalled.
//   Reset empties the queue; stored data words are not cleared.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_scale_macros.svh"

module bounded_deque_with_scale #(
	parameter int DEPTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [2:0]                   opcode,
	input  logic signed [31:0]           operand_value,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic signed [31:0]           data_value,
	output logic [$clog2(DEPTH+1)-1:0]   entry_count,
	output logic [1:0]                   status_code,
	output logic                         last_flag
);
	import bdq_pkg::*;

	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_CW   = CW'(1);

	state_t            state_q, state_d;
	op_t               op_q, op_d;
	logic [WORD_W-1:0] mul_q, mul_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     walk_q, walk_d;

	logic              rsp_valid_q;
	logic [WORD_W-1:0] rsp_data_q, rsp_data_d;
	logic [CW-1:0]     rsp_count_q;
	logic [1:0]        rsp_status_q, rsp_status_d;
	logic              rsp_last_q, rsp_last_d;
	logic              load_rsp;

	cell_cmd_t         cmd;
	logic [WORD_W-1:0] head_data;
	logic [WORD_W-1:0] prod;
	logic [DEPTH-1:0]  occ_vec;
	logic              out_free, accept, walk_last, emit_step;

	bdq_chain #(.DEPTH(DEPTH)) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.head_data (head_data),
		.occ_vec   (occ_vec)
	);

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = !((state_q == ST_IDLE) && out_free);
	assign accept    = cmd_valid && !cmd_stall;
	assign walk_last = (walk_q == ONE_CW);
	assign emit_step = (op_q == OP_DUMP) || walk_last;
	assign prod      = head_data * mul_q;

	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		mul_d        = mul_q;
		count_d      = count_q;
		walk_d       = walk_q;
		load_rsp     = 1'b0;
		rsp_data_d   = '0;
		rsp_status_d = STS_OK;
		rsp_last_d   = 1'b1;
		cmd.act      = CA_HOLD;
		cmd.push_val = operand_value;
		cmd.feed     = head_data;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					load_rsp = 1'b1;
					op_d     = op_t'(opcode);
					unique case (op_t'(opcode))
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (count_q == DEPTH_CW) begin
								rsp_status_d = STS_FULL;
							end else begin
								cmd.act = (op_t'(opcode) == OP_PUSH_FRONT) ? CA_SHR : CA_PUSHB;
								count_d = count_q + ONE_CW;
							end
						end
						OP_POP_FRONT: begin
							if (count_q == '0) begin
								rsp_status_d = STS_EMPTY;
							end else begin
								cmd.act    = CA_SHL;
								rsp_data_d = head_data;
								count_d    = count_q - ONE_CW;
							end
						end
						OP_POP_BACK, OP_DUMP: begin
							if (count_q == '0) begin
								rsp_status_d = STS_EMPTY;
							end else begin
								load_rsp = 1'b0;
								walk_d   = count_q;
								state_d  = ST_WALK;
							end
						end
						OP_SCALE: begin
							if (count_q != '0) begin
								load_rsp = 1'b0;
								walk_d   = count_q;
								mul_d    = operand_value;
								state_d  = ST_WALK;
							end
						end
						OP_CLEAR: begin
							cmd.act = CA_CLR;
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (!emit_step || out_free) begin
					walk_d = walk_q - ONE_CW;
					if (walk_last) state_d = ST_IDLE;
					unique case (op_q)
						OP_DUMP: begin
							cmd.act    = CA_ROT;
							load_rsp   = 1'b1;
							rsp_data_d = head_data;
							rsp_last_d = walk_last;
						end
						OP_POP_BACK: begin
							if (walk_last) begin
								// tail has rotated to the front
								cmd.act    = CA_SHL;
								load_rsp   = 1'b1;
								rsp_data_d = head_data;
								count_d    = count_q - ONE_CW;
							end else begin
								cmd.act = CA_ROT;
							end
						end
						default: begin
							cmd.act  = CA_ROT;
							cmd.feed = prod;
							load_rsp = walk_last;
						end
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_PUSH_FRONT;
			count_q     <= '0;
			walk_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			count_q <= count_d;
			walk_q  <= walk_d;
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_d;
		if (load_rsp) begin
			rsp_data_q   <= rsp_data_d;
			rsp_count_q  <= count_d;
			rsp_status_q <= rsp_status_d;
			rsp_last_q   <= rsp_last_d;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign data_value  = rsp_data_q;
	assign entry_count = rsp_count_q;
	assign status_code = rsp_status_q;
	assign last_flag   = rsp_last_q;

	`BDQ_ASSERT(a_occ_count, $countones(occ_vec) == count_q, "occupied cells disagree with count")
	`BDQ_ASSERT(a_occ_front, occ_vec[0] == (count_q != '0), "front cell occupancy wrong")
	`BDQ_ASSERT_IMPL(a_walk_len, state_q == ST_WALK, walk_q != '0 && walk_q <= count_q, "walk length out of range")
	`BDQ_ASSERT_IMPL(a_load_free, load_rsp, out_free, "response overwritten while stalled")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives bounded_deque_with_scale with a short directed pass and then random
// push/pop/dump/scale sequences, while both handshakes idle and stall at
// random. A scoreboard keeps its own copy of the deque contents, builds the
// expected response words for every accepted command, and checks each
// response word against the oldest one still due.
// ----------------------------------------------------------------------------
module testbench;
	import bdq_pkg::*;

	localparam int DEPTH = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 450;
	localparam int DRAIN_CYCLES = 4 * DEPTH + 20;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	typedef struct {
		logic signed [31:0] data;
		logic [CNT_W-1:0]   count;
		logic [1:0]         status;
		logic               last;
	} rsp_word_t;

	class deque_scoreboard;
		logic [31:0] ring[DEPTH];
		int unsigned head;
		int unsigned fill;
		rsp_word_t   due_q[$];
		int          errors;

		function new();
			head = 0;
			fill = 0;
			errors = 0;
		endfunction

		function void add_word(logic [31:0] data, logic [1:0] status, logic last);
			rsp_word_t w;
			w.data = data;
			w.count = fill[CNT_W-1:0];
			w.status = status;
			w.last = last;
			due_q.push_back(w);
		endfunction

		// apply one accepted command word to the shadow deque
		function void note_cmd(logic [2:0] op, logic [31:0] val);
			logic [31:0] data;
			logic [1:0]  status;
			int unsigned pos;
			data = '0;
			status = STS_OK;
			case (op)
				OP_PUSH_FRONT: begin
					if (fill >= DEPTH) begin
						status = STS_FULL;
					end else begin
						head = (head + DEPTH - 1) % DEPTH;
						ring[head] = val;
						fill++;
					end
				end
				OP_PUSH_BACK: begin
					if (fill >= DEPTH) begin
						status = STS_FULL;
					end else begin
						ring[(head + fill) % DEPTH] = val;
						fill++;
					end
				end
				OP_POP_FRONT: begin
					if (fill == 0) begin
						status = STS_EMPTY;
					end else begin
						data = ring[head];
						head = (head + 1) % DEPTH;
						fill--;
					end
				end
				OP_POP_BACK: begin
					if (fill == 0) begin
						status = STS_EMPTY;
					end else begin
						data = ring[(head + fill - 1) % DEPTH];
						fill--;
					end
				end
				OP_CLEAR: begin
					fill = 0;
					head = 0;
				end
				OP_DUMP: begin
					if (fill == 0) begin
						status = STS_EMPTY;
					end else begin
						for (int i = 0; i < fill; i++)
							add_word(ring[(head + i) % DEPTH], STS_OK, i == fill - 1);
						return;
					end
				end
				OP_SCALE: begin
					for (int i = 0; i < fill; i++) begin
						pos = (head + i) % DEPTH;
						ring[pos] = ring[pos] * val;
					end
				end
				default: ;
			endcase
			add_word(data, status, 1'b1);
		endfunction

		function void check_rsp(logic signed [31:0] data, logic [CNT_W-1:0] count,
				logic [1:0] status, logic last);
			rsp_word_t w;
			if (due_q.size() == 0) begin
				$error("response word with nothing due: data %0d count %0d", data, count);
				errors++;
				return;
			end
			w = due_q.pop_front();
			if (data !== w.data) begin
				$error("data_value mismatch: expected %0d, actual %0d", w.data, data);
				errors++;
			end
			if (count !== w.count) begin
				$error("entry_count mismatch: expected %0d, actual %0d", w.count, count);
				errors++;
			end
			if (status !== w.status) begin
				$error("status_code mismatch: expected %0d, actual %0d", w.status, status);
				errors++;
			end
			if (last !== w.last) begin
				$error("last_flag mismatch: expected %0d, actual %0d", w.last, last);
				errors++;
			end
		endfunction

		function int outstanding();
			return due_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	logic [2:0]         opcode;
	logic signed [31:0] operand_value;
	logic               rsp_valid;
	logic               rsp_stall;
	logic signed [31:0] data_value;
	logic [CNT_W-1:0]   entry_count;
	logic [1:0]         status_code;
	logic               last_flag;

	deque_scoreboard sb;
	int              sent;

	bounded_deque_with_scale #(
		.DEPTH(DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.opcode       (opcode),
		.operand_value(operand_value),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.data_value   (data_value),
		.entry_count  (entry_count),
		.status_code  (status_code),
		.last_flag    (last_flag)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly short idles, now and then a long one
	function automatic int pick_idle(int zero_pct);
		int r;
		r = $urandom_range(99);
		if (r < zero_pct)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_multiplier();
		int r;
		r = $urandom_range(9);
		if (r < 5)
			return $urandom_range(0, 8) - 4;
		else if (r == 5)
			return 32'h8000_0000;
		else if (r == 6)
			return 32'h7fff_ffff;
		else
			return $urandom;
	endfunction

	function automatic logic [2:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 22) return OP_PUSH_FRONT;
		if (r < 44) return OP_PUSH_BACK;
		if (r < 59) return OP_POP_FRONT;
		if (r < 74) return OP_POP_BACK;
		if (r < 83) return OP_DUMP;
		if (r < 92) return OP_SCALE;
		if (r < 97) return OP_CLEAR;
		return OP_UNUSED;
	endfunction

	// present one command word and hold it until the block takes it
	task automatic send_cmd(logic [2:0] op, logic [31:0] val);
		int gap;
		gap = pick_idle(50);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		opcode <= op;
		operand_value <= val;
		do @(posedge clk); while (cmd_stall);
		sb.note_cmd(op, val);
		sent++;
	endtask

	task automatic send_random(logic [2:0] op);
		if (op == OP_SCALE)
			send_cmd(op, pick_multiplier());
		else
			send_cmd(op, pick_word());
	endtask

	// drop valid so the last word is not taken twice, then wait for responses
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	task automatic run_directed();
		send_cmd(OP_POP_FRONT, 32'h1234_5678);
		send_cmd(OP_POP_BACK, 32'h0);
		send_cmd(OP_DUMP, 32'h0);
		send_cmd(OP_SCALE, 32'd5);
		send_cmd(OP_UNUSED, 32'hdead_beef);
		send_cmd(OP_PUSH_BACK, 32'h7fff_ffff);
		send_cmd(OP_PUSH_BACK, 32'h8000_0000);
		send_cmd(OP_PUSH_FRONT, 32'hffff_ffff);
		send_cmd(OP_PUSH_FRONT, 32'h0);
		send_cmd(OP_PUSH_BACK, 32'd1);
		send_cmd(OP_DUMP, 32'h0);
		send_cmd(OP_SCALE, 32'hffff_ffff);
		send_cmd(OP_DUMP, 32'h0);
		send_cmd(OP_SCALE, 32'h7fff_ffff);
		send_cmd(OP_POP_FRONT, 32'h0);
		send_cmd(OP_POP_BACK, 32'h0);
		send_cmd(OP_UNUSED, 32'h0);
		send_cmd(OP_DUMP, 32'h0);
		send_cmd(OP_CLEAR, 32'hffff_ffff);
		send_cmd(OP_DUMP, 32'h0);
		send_cmd(OP_PUSH_FRONT, 32'h5555_5555);
		send_cmd(OP_PUSH_BACK, 32'haaaa_aaaa);
		send_cmd(OP_POP_BACK, 32'h0);
		send_cmd(OP_POP_FRONT, 32'h0);
		send_cmd(OP_POP_FRONT, 32'h0);
	endtask

	task automatic run_random();
		int n;
		int kind;
		while (sent < RANDOM_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 25) begin
				// fill past full, then at random dump the full ring
				n = DEPTH - sb.fill + $urandom_range(1, 3);
				repeat (n)
					send_random($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT);
				if ($urandom_range(1))
					send_random(OP_DUMP);
			end else if (kind < 42) begin
				// drain past empty
				n = sb.fill + $urandom_range(1, 2);
				repeat (n)
					send_random($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT);
			end else begin
				n = $urandom_range(8, 20);
				repeat (n) begin
					if ($urandom_range(99) < 3)
						wait_drained();
					send_random(pick_op());
				end
			end
		end
	endtask

	initial begin
		sb = new();
		sent = 0;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		opcode <= OP_PUSH_FRONT;
		operand_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		// hold the sender off until every response word is back
		wait_drained();
		run_random();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// response side back-pressure: run stretches broken by stalls
	initial begin
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(100, 300)) @(posedge clk);
			else
				repeat (pick_idle(0)) @(posedge clk);
			rsp_stall <= 1'b1;
			repeat (pick_idle(0)) @(posedge clk);
			rsp_stall <= 1'b0;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_rsp(data_value, entry_count, status_code, last_flag);
	end

	initial begin
		#30_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bdq_chain.sv
rtl/bounded_deque_with_scale.sv
dv/testbench.sv
